FILE: design/arpc_pkg.sv
// Shared types and constants for the ARP cache with expiry.
// No dependencies; imported by the core.
package arpc_pkg;

  localparam int ACTION_W = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int SLOT_W   = 5;
  localparam int TIME_W   = 32;
  localparam int LIFE_W   = 16;
  localparam int CIDX_W   = 2;

  localparam logic [LIFE_W-1:0] PENDING_LIFE_RST  = 16'd2;
  localparam logic [LIFE_W-1:0] RESOLVED_LIFE_RST = 16'd300;

  localparam logic [CIDX_W-1:0] CFG_PENDING_LIFE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RESOLVED_LIFE = 2'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP  = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_REPLY   = 2'd2,
    ACT_FINISH  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_SOLVED  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_FIN   = 2'd2,
    S_WRITE = 2'd3
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    status_t           status;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/arp_cache_with_expiry_core.sv
// ARP cache core: slot store, scan sequencer, expiry and replacement logic.
// Depends on arpc_pkg and arpc_ram.
//
// Command-style block. An item is taken when start is high and busy is low;
// busy stays high until the result is out. The result appears for one cycle
// with done high, in the cycle that busy drops; it cannot be held off. The
// slot store is one RAM read one slot per cycle by a shared scan sequencer,
// so the scan sets the time. Lookup and reply stop at the first hit, and
// reply then writes the store; reserve stops at the first free slot, else
// scans every slot, then writes; finish reads only the selected slot. A new
// item may start in the cycle done is high. Per-slot valid flops are cleared
// by reset, so no clearing pass is needed. Lifetime registers are written on
// the cfg channel, which is always ready; write it only while idle.
module arp_cache_with_expiry_core #(
  parameter int ENTRIES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [arpc_pkg::ACTION_W-1:0]  action,
  input  logic [arpc_pkg::IP_W-1:0]      ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]     mac_address,
  input  logic [arpc_pkg::SLOT_W-1:0]    slot_index,
  input  logic [arpc_pkg::TIME_W-1:0]    current_time,
  output logic                           done,
  output logic                           found,
  output logic [arpc_pkg::SLOT_W-1:0]    slot,
  output logic [arpc_pkg::MAC_W-1:0]     mac_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arpc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [arpc_pkg::LIFE_W-1:0]    cfg_data
);

  import arpc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);

  state_t state, state_next;

  action_t           act;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [SLOT_W-1:0] sel_r;
  logic [TIME_W-1:0] now_r;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     pick, pick_next;
  logic [TIME_W-1:0] oldest, oldest_next;
  logic [AW-1:0]     tgt, tgt_next;
  logic [LIFE_W-1:0] pending_life;
  logic [LIFE_W-1:0] resolved_life;
  logic [ENTRIES-1:0] valid;

  // store interface
  logic              ram_we;
  logic [AW-1:0]     rd_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            wr_entry;

  // datapath decisions
  logic [AW-1:0]     sel_a;
  logic [AW-1:0]     look_a;
  logic              sel_ok;
  entry_t            e;
  entry_t            s;
  logic              expired;
  logic              last;
  logic              ip_eq;
  logic              less_old;
  logic              lookup_hit;
  logic              reply_hit;
  logic              is_free;
  logic              fin_hit;

  // output-block signals
  logic              clr_en;
  logic [AW-1:0]     clr_a;
  logic              res_load;
  logic              res_found;
  logic [SLOT_W-1:0] res_slot;
  logic [MAC_W-1:0]  res_mac;

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tgt),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // slot under evaluation; invalid slots read as all zero (free)
  always_comb begin
    sel_a      = AW'(sel_r);
    sel_ok     = ({{(32 - SLOT_W){1'b0}}, sel_r} < 32'(ENTRIES));
    look_a     = (state == S_FIN) ? sel_a : ptr;
    e          = valid[look_a] ? entry_t'(ram_rdata) : '0;
    expired    = (e.expiry < now_r);
    s          = expired ? '0 : e;
    last       = (ptr == LAST_A);
    ip_eq      = (s.ip == ip_r);
    less_old   = (s.expiry < oldest);
    lookup_hit = ip_eq && (s.status == ST_SOLVED);
    reply_hit  = ip_eq && (s.status == ST_PENDING);
    is_free    = (s.status == ST_FREE);
    fin_hit    = sel_ok && (e.ip == ip_r) && (e.status == ST_SOLVED);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (action_t'(action) == ACT_FINISH) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        case (act)
          ACT_LOOKUP: begin
            if (lookup_hit || last) state_next = S_IDLE;
          end
          ACT_RESERVE: begin
            if (is_free || last) state_next = S_WRITE;
          end
          ACT_REPLY: begin
            if (reply_hit) state_next = S_WRITE;
            else if (last) state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FIN:   state_next = S_IDLE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    rd_addr     = ptr + AW'(1);
    ram_we      = 1'b0;
    clr_en      = 1'b0;
    clr_a       = ptr;
    res_load    = 1'b0;
    res_found   = 1'b0;
    res_slot    = '0;
    res_mac     = '0;
    tgt_next    = tgt;
    oldest_next = oldest;
    pick_next   = pick;

    wr_entry.ip = ip_r;
    if (act == ACT_RESERVE) begin
      wr_entry.mac    = '0;
      wr_entry.status = ST_PENDING;
      wr_entry.expiry = now_r + {{(TIME_W - LIFE_W){1'b0}}, pending_life};
    end else begin
      wr_entry.mac    = mac_r;
      wr_entry.status = ST_SOLVED;
      wr_entry.expiry = now_r + {{(TIME_W - LIFE_W){1'b0}}, resolved_life};
    end

    case (state)
      S_IDLE: begin
        rd_addr = (action_t'(action) == ACT_FINISH) ? AW'(slot_index) : '0;
        oldest_next = '1;
        pick_next   = '0;
      end
      S_SCAN: begin
        clr_en = expired;
        case (act)
          ACT_LOOKUP: begin
            if (lookup_hit) begin
              res_load  = 1'b1;
              res_found = 1'b1;
              res_slot  = SLOT_W'(ptr);
              res_mac   = s.mac;
            end else if (last) begin
              res_load = 1'b1;
            end
          end
          ACT_RESERVE: begin
            if (is_free) begin
              tgt_next = ptr;
            end else if (less_old) begin
              oldest_next = s.expiry;
              pick_next   = ptr;
              tgt_next    = ptr;
            end else begin
              tgt_next = pick;
            end
          end
          ACT_REPLY: begin
            if (reply_hit) begin
              tgt_next = ptr;
            end else if (last) begin
              res_load = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        res_load = 1'b1;
        clr_a    = sel_a;
        clr_en   = sel_ok && !fin_hit;
        if (fin_hit) begin
          res_found = 1'b1;
          res_slot  = sel_r;
          res_mac   = e.mac;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        res_load  = 1'b1;
        res_found = 1'b1;
        res_slot  = SLOT_W'(tgt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      valid         <= '0;
      pending_life  <= PENDING_LIFE_RST;
      resolved_life <= RESOLVED_LIFE_RST;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (clr_en) begin
        valid[clr_a] <= 1'b0;
      end
      if (ram_we) begin
        valid[tgt] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PENDING_LIFE) begin
          pending_life <= cfg_data;
        end else if (cfg_index == CFG_RESOLVED_LIFE) begin
          resolved_life <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      act   <= action_t'(action);
      ip_r  <= ip_address;
      mac_r <= mac_address;
      sel_r <= slot_index;
      now_r <= current_time;
      ptr   <= '0;
    end else if (state == S_SCAN) begin
      ptr <= ptr + AW'(1);
    end
    oldest <= oldest_next;
    pick   <= pick_next;
    tgt    <= tgt_next;
    if (res_load) begin
      found   <= res_found;
      slot    <= res_slot;
      mac_out <= res_mac;
    end
  end

  // result beat lands only once the block is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // a store write always reports success on the next beat
  a_write_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (done && found))
    else $error("write not followed by a successful result");

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a miss reports zero slot and MAC
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (slot == '0 && mac_out == '0))
    else $error("miss with nonzero payload");

endmodule

FILE: verif/arp_cache_checker.sv
// Scoreboard for the ARP cache core: keeps its own copy of the slot store and
// lifetimes, predicts one answer per accepted command and checks each done beat.
// Depends on arpc_pkg.
module arp_cache_checker #(
  parameter int ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [arpc_pkg::ACTION_W-1:0] action,
  input  logic [arpc_pkg::IP_W-1:0]     ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]    mac_address,
  input  logic [arpc_pkg::SLOT_W-1:0]   slot_index,
  input  logic [arpc_pkg::TIME_W-1:0]   current_time,
  input  logic                          done,
  input  logic                          found,
  input  logic [arpc_pkg::SLOT_W-1:0]   slot,
  input  logic [arpc_pkg::MAC_W-1:0]    mac_out,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [arpc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [arpc_pkg::LIFE_W-1:0]   cfg_data,
  output int                            fail_cnt,
  output int                            open_cnt
);
  import arpc_pkg::*;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac;
  } answer_t;

  logic [IP_W-1:0]   ip_tab  [ENTRIES];
  logic [MAC_W-1:0]  mac_tab [ENTRIES];
  status_t           stat_tab[ENTRIES];
  logic [TIME_W-1:0] exp_tab [ENTRIES];
  logic [LIFE_W-1:0] pend_life;
  logic [LIFE_W-1:0] solved_life;
  answer_t           answers_due[$];

  function automatic void wipe_slot(int i);
    ip_tab[i]   = '0;
    mac_tab[i]  = '0;
    stat_tab[i] = ST_FREE;
    exp_tab[i]  = '0;
  endfunction

  // expiry equal to now is still alive
  function automatic void age_out(int i, logic [TIME_W-1:0] now);
    if (exp_tab[i] < now) wipe_slot(i);
  endfunction

  function automatic answer_t run_arp_action(action_t act, logic [IP_W-1:0] ip,
                                             logic [MAC_W-1:0] mac,
                                             logic [SLOT_W-1:0] sel,
                                             logic [TIME_W-1:0] now);
    answer_t           ans;
    int                i;
    int                pick;
    logic              hit;
    logic [TIME_W-1:0] oldest;
    ans    = '0;
    hit    = 1'b0;
    pick   = 0;
    oldest = '1;
    case (act)
      ACT_LOOKUP: begin
        for (i = 0; i < ENTRIES && !hit; i++) begin
          age_out(i, now);
          if (stat_tab[i] == ST_SOLVED && ip_tab[i] == ip) begin
            hit       = 1'b1;
            ans.found = 1'b1;
            ans.slot  = SLOT_W'(i);
            ans.mac   = mac_tab[i];
          end
        end
      end
      ACT_RESERVE: begin
        // first free slot wins; with none free, the earliest expiry (lowest index on a tie)
        i = 0;
        while (i < ENTRIES && !hit) begin
          age_out(i, now);
          if (stat_tab[i] == ST_FREE) begin
            hit = 1'b1;
          end else begin
            if (exp_tab[i] < oldest) begin
              oldest = exp_tab[i];
              pick   = i;
            end
            i++;
          end
        end
        if (!hit) i = pick;
        ip_tab[i]   = ip;
        mac_tab[i]  = '0;
        stat_tab[i] = ST_PENDING;
        exp_tab[i]  = now + TIME_W'(pend_life);
        ans.found   = 1'b1;
        ans.slot    = SLOT_W'(i);
      end
      ACT_REPLY: begin
        for (i = 0; i < ENTRIES && !hit; i++) begin
          age_out(i, now);
          if (ip_tab[i] == ip && stat_tab[i] == ST_PENDING) begin
            mac_tab[i]  = mac;
            stat_tab[i] = ST_SOLVED;
            exp_tab[i]  = now + TIME_W'(solved_life);
            hit         = 1'b1;
            ans.found   = 1'b1;
            ans.slot    = SLOT_W'(i);
          end
        end
      end
      default: begin
        // finish: no aging, the selected slot is kept only if solved for this ip
        if (int'(sel) < ENTRIES) begin
          if (ip_tab[sel] == ip && stat_tab[sel] == ST_SOLVED) begin
            ans.found = 1'b1;
            ans.slot  = sel;
            ans.mac   = mac_tab[sel];
          end else begin
            wipe_slot(int'(sel));
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic void check_field(string what, logic [MAC_W-1:0] want,
                                      logic [MAC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) wipe_slot(i);
      pend_life   = PENDING_LIFE_RST;
      solved_life = RESOLVED_LIFE_RST;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: found %h slot %h mac %h",
                   $time, found, slot, mac_out);
          fail_cnt++;
        end else begin
          want = answers_due.pop_front();
          check_field("found", MAC_W'(want.found), MAC_W'(found));
          check_field("slot", MAC_W'(want.slot), MAC_W'(slot));
          check_field("mac_out", want.mac, mac_out);
        end
      end
      if (start && !busy) begin
        answers_due.push_back(run_arp_action(action_t'(action), ip_address, mac_address,
                                             slot_index, current_time));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PENDING_LIFE:  pend_life = cfg_data;
          CFG_RESOLVED_LIFE: solved_life = cfg_data;
          default: ;
        endcase
      end
    end
    open_cnt <= answers_due.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the ARP cache core: clock, reset, command and register
// stimulus, and the verdict. Depends on arpc_pkg, the core and arp_cache_checker.
module tb;
  import arpc_pkg::*;

  localparam int ENTRIES   = 32;
  localparam int POOL_N    = 40;
  localparam int PHASE_N   = 7;
  localparam int PER_PHASE = 265;
  localparam int LIMIT     = 500000;
  localparam logic [IP_W-1:0]   SWEEP_IP     = 32'hC0A8_FFFE;
  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                start        = 1'b0;
  logic [ACTION_W-1:0] action       = '0;
  logic [IP_W-1:0]     ip_address   = '0;
  logic [MAC_W-1:0]    mac_address  = '0;
  logic [SLOT_W-1:0]   slot_index   = '0;
  logic [TIME_W-1:0]   current_time = '0;
  logic                cfg_valid    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index    = '0;
  logic [LIFE_W-1:0]   cfg_data     = '0;
  logic                busy;
  logic                done;
  logic                found;
  logic [SLOT_W-1:0]   slot;
  logic [MAC_W-1:0]    mac_out;
  logic                cfg_ready;
  int                  fail_cnt;
  int                  open_cnt;

  int                  cycles    = 0;
  int                  sent      = 0;
  bit                  gaps_on   = 1'b1;
  logic [SLOT_W-1:0]   last_slot = '0;
  logic [TIME_W-1:0]   now_t     = '0;
  logic [LIFE_W-1:0]   pend_life = PENDING_LIFE_RST;
  logic [IP_W-1:0]     ip_pool[POOL_N];

  arp_cache_with_expiry_core #(.ENTRIES(ENTRIES)) i_dut (
    .clk, .rst, .start, .busy, .action, .ip_address, .mac_address, .slot_index,
    .current_time, .done, .found, .slot, .mac_out, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  arp_cache_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk, .rst, .start, .busy, .action, .ip_address, .mac_address, .slot_index,
    .current_time, .done, .found, .slot, .mac_out, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .fail_cnt, .open_cnt
  );

  always #10 clk = ~clk;

  // last reported slot steers finish commands toward live entries
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (done) last_slot <= slot;
    if (cycles > LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [IP_W-1:0] pool_ip();
    return ip_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  task automatic tick();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 5 && r < 8) now_t += 1;
    else if (r == 8) now_t += $urandom_range(2, 8);
    else if (r == 9) now_t += $urandom_range(0, 400);
  endtask

  task automatic issue(input action_t act, input logic [IP_W-1:0] ip,
                       input logic [MAC_W-1:0] mac, input logic [SLOT_W-1:0] sel,
                       input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    ip_address   <= ip;
    mac_address  <= mac;
    slot_index   <= sel;
    current_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // open_cnt is registered, so look only after an edge has passed
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0 || busy) @(posedge clk);
  endtask

  task automatic program_regs(input logic [LIFE_W-1:0] p, input logic [LIFE_W-1:0] r,
                              input bit with_unmapped);
    logic [CIDX_W-1:0] idx[3];
    logic [LIFE_W-1:0] val[3];
    int                k;
    idx[0] = CFG_PENDING_LIFE;
    idx[1] = CFG_RESOLVED_LIFE;
    idx[2] = CFG_UNMAPPED;
    val[0] = p;
    val[1] = r;
    val[2] = 16'($urandom);
    for (k = 0; k < (with_unmapped ? 3 : 2); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    pend_life = p;
  endtask

  // clear every slot, fill all of them to expire at the top of the time range,
  // then reserve once more: every expiry is at maximum, so slot 0 is replaced
  task automatic sweep_fill();
    int k;
    for (k = 0; k < ENTRIES; k++) issue(ACT_FINISH, SWEEP_IP, rand_mac(), SLOT_W'(k), now_t);
    now_t = 32'hFFFF_FFFF - TIME_W'(pend_life);
    for (k = 0; k <= ENTRIES; k++) begin
      issue(ACT_RESERVE, {8'd172, 24'(k)}, rand_mac(), SLOT_W'($urandom), now_t);
    end
  endtask

  initial begin
    int                ph;
    int                goal;
    int                roll;
    logic [IP_W-1:0]   ip;
    logic [LIFE_W-1:0] p;
    logic [LIFE_W-1:0] r;
    for (int k = 0; k < POOL_N; k++) ip_pool[k] = {8'd10, 24'($urandom)};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cache, full round trip, expiry boundary, wrap of the expiry sum
    issue(ACT_LOOKUP,  32'h0,         48'h0,              5'd0,  32'd0);
    issue(ACT_RESERVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd31, 32'd0);
    issue(ACT_REPLY,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd0,  32'd1);
    issue(ACT_LOOKUP,  32'hFFFF_FFFF, 48'h0,              5'd0,  32'd1);
    issue(ACT_FINISH,  32'hFFFF_FFFF, 48'h0,              5'd0,  32'd1);
    issue(ACT_RESERVE, 32'h0,         48'h1234_5678_9ABC, 5'd0,  32'd1);
    issue(ACT_REPLY,   32'h0,         48'h0,              5'd1,  32'd3);
    issue(ACT_LOOKUP,  32'h0,         48'h0,              5'd0,  32'd3);
    issue(ACT_REPLY,   32'h0A00_0001, 48'hAAAA_AAAA_AAAA, 5'd0,  32'd3);
    issue(ACT_RESERVE, 32'h0A00_0001, 48'h0,              5'd0,  32'd3);
    issue(ACT_LOOKUP,  32'h0A00_0001, 48'h0,              5'd0,  32'd6);
    issue(ACT_FINISH,  32'hFFFF_FFFF, 48'h0,              5'd1,  32'd6);
    issue(ACT_LOOKUP,  32'h0,         48'h0,              5'd0,  32'd6);
    issue(ACT_FINISH,  32'h0,         48'h0,              5'd31, 32'd6);
    issue(ACT_RESERVE, 32'h0A00_0002, 48'h0,              5'd0,  32'hFFFF_FFFF);
    issue(ACT_REPLY,   32'h0A00_0002, 48'h5555_5555_5555, 5'd0,  32'hFFFF_FFFF);
    issue(ACT_RESERVE, 32'h0A00_0003, 48'h0,              5'd0,  32'd0);
    issue(ACT_REPLY,   32'h0A00_0003, 48'h5555_5555_5555, 5'd0,  32'd2);
    issue(ACT_LOOKUP,  32'h0A00_0003, 48'h0,              5'd0,  32'd302);
    issue(ACT_LOOKUP,  32'h0A00_0003, 48'h0,              5'd0,  32'd303);
    issue(ACT_FINISH,  32'h0A00_0003, 48'hFFFF_FFFF_FFFF, 5'd0,  32'd303);
    now_t = 32'd400;

    for (ph = 0; ph < PHASE_N; ph++) begin
      settle();
      case (ph)
        0: begin p = PENDING_LIFE_RST; r = RESOLVED_LIFE_RST; end
        1: begin p = '0; r = '0; end
        2: begin p = '1; r = '1; end
        3: begin p = '0; r = '1; end
        4: begin p = '1; r = '0; end
        5: begin p = 16'($urandom); r = 16'($urandom); end
        default: begin
          p = 16'($urandom_range(1, 8));
          r = 16'($urandom_range(20, 600));
        end
      endcase
      program_regs(p, r, ph == 3);
      gaps_on = (ph < PHASE_N - 1);
      if (ph == 2) now_t = 32'hFFFF_FF00;
      if (ph == 4) now_t = 32'hFFFF_FFFF - 32'd50;
      if (ph == 1 || ph == 2) sweep_fill();

      goal = sent + PER_PHASE;
      while (sent < goal) begin
        roll = $urandom_range(0, 99);
        ip   = pool_ip();
        if (roll < 65) begin
          // typical resolution: reserve, usually answered, then maybe used and released
          issue(ACT_RESERVE, ip, rand_mac(), SLOT_W'($urandom), now_t);
          tick();
          if ($urandom_range(0, 9) < 8) begin
            issue(ACT_REPLY, ip, rand_mac(), SLOT_W'($urandom), now_t);
            tick();
          end
          repeat ($urandom_range(0, 2)) begin
            issue(ACT_LOOKUP, ip, rand_mac(), SLOT_W'($urandom), now_t);
            tick();
          end
          if ($urandom_range(0, 2) == 0) issue(ACT_FINISH, ip, rand_mac(), last_slot, now_t);
        end else if (roll < 80) begin
          issue(ACT_LOOKUP, ip, rand_mac(), SLOT_W'($urandom), now_t);
          tick();
        end else if (roll < 88) begin
          issue(ACT_FINISH, ip, rand_mac(),
                $urandom_range(0, 1) ? last_slot : SLOT_W'($urandom), now_t);
        end else if (roll < 93) begin
          issue(ACT_REPLY, ip, rand_mac(), SLOT_W'($urandom), now_t);
          tick();
        end else begin
          issue(action_t'($urandom_range(0, 3)), $urandom, rand_mac(), SLOT_W'($urandom),
                $urandom_range(0, 1) ? TIME_W'($urandom) : now_t);
        end
      end
    end

    settle();
    repeat (ENTRIES + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
